### sv/mie_pkg.sv
// Package for the 6502 execute unit: transaction structs, mnemonic codes,
// flag bit positions and a small ALU helper function. No dependencies.
package mie_pkg;

  // Mnemonic codes, alphabetical
  typedef enum logic [5:0] {
    ADC = 6'd0,  AND_ = 6'd1, ASL = 6'd2,  BCC = 6'd3,  BCS = 6'd4,  BEQ = 6'd5,
    BIT = 6'd6,  BMI = 6'd7,  BNE = 6'd8,  BPL = 6'd9,  BVC = 6'd10, BVS = 6'd11,
    CLC = 6'd12, CLD = 6'd13, CLI = 6'd14, CLV = 6'd15, CMP = 6'd16, CPX = 6'd17,
    CPY = 6'd18, DEC = 6'd19, DEX = 6'd20, DEY = 6'd21, EOR = 6'd22, INC = 6'd23,
    INX = 6'd24, INY = 6'd25, JMP = 6'd26, JSR = 6'd27, LDA = 6'd28, LDX = 6'd29,
    LDY = 6'd30, LSR = 6'd31, NOP = 6'd32, ORA = 6'd33, PHA = 6'd34, PHP = 6'd35,
    PLA = 6'd36, PLP = 6'd37, ROL = 6'd38, ROR = 6'd39, RTS = 6'd40, SBC = 6'd41,
    SEC = 6'd42, SED = 6'd43, SEI = 6'd44, STA = 6'd45, STX = 6'd46, STY = 6'd47,
    TAX = 6'd48, TAY = 6'd49, TSX = 6'd50, TXA = 6'd51, TXS = 6'd52, TYA = 6'd53
  } mnemonic_t;

  // Status bit positions, NV-BDIZC
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;

  typedef struct packed {
    logic [5:0]  mode;
    logic        accumulator_form;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [15:0] fetch_pc;
  } in_item_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] new_pc;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
  } out_item_t;

  // Classified instruction held in the queue
  typedef struct packed {
    mnemonic_t   mode;
    logic        accf;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [15:0] fetch_pc;
    logic [15:0] target;     // branch target
    logic [15:0] ret_pc;     // JSR return address
    logic        two_phase;  // needs a stack access phase first
    logic        is_pull;
  } op_item_t;

  // Update N and Z from a value
  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FL_Z] = (v == 8'h00);
    r[FL_N] = v[7];
    return r;
  endfunction

endpackage

### sv/mie_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module mie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### sv/mie_front.sv
// Front end: accepts instruction transactions and classifies them for the queue.
// Depends on mie_pkg.
module mie_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  mie_pkg::in_item_t   in_item,
  input  logic                q_full,
  output logic                q_push,
  output mie_pkg::op_item_t   q_item
);

  logic [15:0] offset;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify and precompute addresses
  always_comb begin
    offset          = {{8{in_item.operand[7]}}, in_item.operand};
    q_item.mode     = mie_pkg::mnemonic_t'(in_item.mode);
    q_item.accf     = in_item.accumulator_form;
    q_item.operand  = in_item.operand;
    q_item.address  = in_item.address;
    q_item.fetch_pc = in_item.fetch_pc;
    q_item.target   = in_item.fetch_pc + offset;
    q_item.ret_pc   = in_item.fetch_pc - 16'd1;
    q_item.is_pull  = (q_item.mode == mie_pkg::PLA) || (q_item.mode == mie_pkg::PLP) ||
                      (q_item.mode == mie_pkg::RTS);
    q_item.two_phase = q_item.is_pull || (q_item.mode == mie_pkg::JSR);
  end

endmodule

### sv/mie_fifo.sv
// Two-entry queue between front and back end.
// Depends on mie_pkg.
module mie_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mie_pkg::op_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mie_pkg::op_item_t head
);

  mie_pkg::op_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/mie_back.sv
// Back end: register file, flags, stack RAM and output register.
// Depends on mie_pkg and mie_ram.
module mie_back #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mie_pkg::op_item_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mie_pkg::out_item_t out_item
);

  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_RUN    = 2'b01,
    ST_SECOND = 2'b10
  } state_t;

  state_t state;
  logic [7:0] acc, idx_x, idx_y, sp, flags;

  logic [7:0] acc_next, x_next, y_next, sp_next, flags_next;
  logic [15:0] pc_next;
  logic        wr_next;
  logic [7:0]  wd_next;
  logic        stk_wr;
  logic [7:0]  stk_wd;
  logic [7:0]  rd0, rd1;
  logic        ram_we;
  logic [7:0]  ram_wd;
  logic        out_free;
  logic        phase1;

  // Stack pointer modulo depth, by compare and subtract
  function automatic logic [AW-1:0] stk_idx(input logic [7:0] v);
    logic [11:0] r;
    r = {4'd0, v};
    for (int s = 3; s >= 0; s--) begin
      if (r >= 12'(STACK_DEPTH << s)) r = r - 12'(STACK_DEPTH << s);
    end
    return r[AW-1:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign phase1   = (state == ST_RUN) && head_valid && head.two_phase;
  assign pop      = head_valid && out_free && ((state == ST_SECOND) || !head.two_phase);

  // Stack store
  assign ram_we = (phase1 && (head.mode == mie_pkg::JSR)) || (pop && stk_wr);
  assign ram_wd = phase1 ? head.ret_pc[15:8] : stk_wd;

  mie_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (stk_idx(sp)),
    .wdata  (ram_wd),
    .raddr0 (stk_idx(sp + 8'd1)),
    .raddr1 (stk_idx(sp + 8'd2)),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // Execute
  always_comb begin
    logic [8:0] sum;
    logic [7:0] m;
    logic [7:0] v;
    logic [7:0] r;
    logic       take;
    acc_next   = acc;
    x_next     = idx_x;
    y_next     = idx_y;
    sp_next    = sp;
    flags_next = flags;
    pc_next    = head.fetch_pc;
    wr_next    = 1'b0;
    wd_next    = 8'h00;
    stk_wr     = 1'b0;
    stk_wd     = 8'h00;
    take       = 1'b0;
    m          = (head.mode == mie_pkg::SBC) ? ~head.operand : head.operand;
    sum        = {1'b0, acc} + {1'b0, m} + {8'd0, flags[mie_pkg::FL_C]};
    v          = head.accf ? acc : head.operand;
    r          = 8'h00;
    unique case (head.mode)
      mie_pkg::ADC, mie_pkg::SBC: begin
        acc_next = sum[7:0];
        flags_next[mie_pkg::FL_C] = sum[8];
        flags_next[mie_pkg::FL_V] = (acc[7] ^ sum[7]) & (m[7] ^ sum[7]);
        flags_next = mie_pkg::set_nz(flags_next, sum[7:0]);
      end
      mie_pkg::AND_: begin
        acc_next = acc & head.operand;
        flags_next = mie_pkg::set_nz(flags, acc_next);
      end
      mie_pkg::ORA: begin
        acc_next = acc | head.operand;
        flags_next = mie_pkg::set_nz(flags, acc_next);
      end
      mie_pkg::EOR: begin
        acc_next = acc ^ head.operand;
        flags_next = mie_pkg::set_nz(flags, acc_next);
      end
      mie_pkg::ASL, mie_pkg::LSR, mie_pkg::ROL, mie_pkg::ROR: begin
        if (head.mode == mie_pkg::ASL || head.mode == mie_pkg::ROL) begin
          flags_next[mie_pkg::FL_C] = v[7];
          r = {v[6:0], (head.mode == mie_pkg::ROL) & flags[mie_pkg::FL_C]};
        end else begin
          flags_next[mie_pkg::FL_C] = v[0];
          r = {(head.mode == mie_pkg::ROR) & flags[mie_pkg::FL_C], v[7:1]};
        end
        flags_next = mie_pkg::set_nz(flags_next, r);
        if (head.accf) begin
          acc_next = r;
        end else begin
          wr_next = 1'b1;
          wd_next = r;
        end
      end
      mie_pkg::BCC: take = !flags[mie_pkg::FL_C];
      mie_pkg::BCS: take = flags[mie_pkg::FL_C];
      mie_pkg::BEQ: take = flags[mie_pkg::FL_Z];
      mie_pkg::BNE: take = !flags[mie_pkg::FL_Z];
      mie_pkg::BMI: take = flags[mie_pkg::FL_N];
      mie_pkg::BPL: take = !flags[mie_pkg::FL_N];
      mie_pkg::BVC: take = !flags[mie_pkg::FL_V];
      mie_pkg::BVS: take = flags[mie_pkg::FL_V];
      mie_pkg::BIT: begin
        flags_next[mie_pkg::FL_Z] = ((acc & head.operand) == 8'h00);
        flags_next[mie_pkg::FL_V] = head.operand[6];
        flags_next[mie_pkg::FL_N] = head.operand[7];
      end
      mie_pkg::CLC: flags_next[mie_pkg::FL_C] = 1'b0;
      mie_pkg::CLD: flags_next[mie_pkg::FL_D] = 1'b0;
      mie_pkg::CLI: flags_next[mie_pkg::FL_I] = 1'b0;
      mie_pkg::CLV: flags_next[mie_pkg::FL_V] = 1'b0;
      mie_pkg::SEC: flags_next[mie_pkg::FL_C] = 1'b1;
      mie_pkg::SED: flags_next[mie_pkg::FL_D] = 1'b1;
      mie_pkg::SEI: flags_next[mie_pkg::FL_I] = 1'b1;
      mie_pkg::CMP, mie_pkg::CPX, mie_pkg::CPY: begin
        v = (head.mode == mie_pkg::CMP) ? acc :
            (head.mode == mie_pkg::CPX) ? idx_x : idx_y;
        flags_next[mie_pkg::FL_C] = (v >= head.operand);
        flags_next = mie_pkg::set_nz(flags_next, v - head.operand);
      end
      mie_pkg::DEC, mie_pkg::INC: begin
        wr_next = 1'b1;
        wd_next = (head.mode == mie_pkg::INC) ? head.operand + 8'd1 : head.operand - 8'd1;
        flags_next = mie_pkg::set_nz(flags, wd_next);
      end
      mie_pkg::DEX, mie_pkg::INX: begin
        x_next = (head.mode == mie_pkg::INX) ? idx_x + 8'd1 : idx_x - 8'd1;
        flags_next = mie_pkg::set_nz(flags, x_next);
      end
      mie_pkg::DEY, mie_pkg::INY: begin
        y_next = (head.mode == mie_pkg::INY) ? idx_y + 8'd1 : idx_y - 8'd1;
        flags_next = mie_pkg::set_nz(flags, y_next);
      end
      mie_pkg::JMP: pc_next = head.address;
      mie_pkg::JSR: begin
        // high byte pushed in the first phase, low byte here
        stk_wr  = 1'b1;
        stk_wd  = head.ret_pc[7:0];
        sp_next = sp - 8'd1;
        pc_next = head.address;
      end
      mie_pkg::LDA: begin
        acc_next = head.operand;
        flags_next = mie_pkg::set_nz(flags, head.operand);
      end
      mie_pkg::LDX: begin
        x_next = head.operand;
        flags_next = mie_pkg::set_nz(flags, head.operand);
      end
      mie_pkg::LDY: begin
        y_next = head.operand;
        flags_next = mie_pkg::set_nz(flags, head.operand);
      end
      mie_pkg::PHA, mie_pkg::PHP: begin
        stk_wr  = 1'b1;
        stk_wd  = (head.mode == mie_pkg::PHA) ? acc : (flags | 8'h30);
        sp_next = sp - 8'd1;
      end
      mie_pkg::PLA: begin
        acc_next = rd0;
        sp_next  = sp + 8'd1;
        flags_next = mie_pkg::set_nz(flags, rd0);
      end
      mie_pkg::PLP: begin
        flags_next = (rd0 & 8'hEF) | 8'h20;
        sp_next    = sp + 8'd1;
      end
      mie_pkg::RTS: begin
        pc_next = {rd1, rd0} + 16'd1;
        sp_next = sp + 8'd2;
      end
      mie_pkg::STA: begin wr_next = 1'b1; wd_next = acc;   end
      mie_pkg::STX: begin wr_next = 1'b1; wd_next = idx_x; end
      mie_pkg::STY: begin wr_next = 1'b1; wd_next = idx_y; end
      mie_pkg::TAX: begin x_next = acc; flags_next = mie_pkg::set_nz(flags, acc); end
      mie_pkg::TAY: begin y_next = acc; flags_next = mie_pkg::set_nz(flags, acc); end
      mie_pkg::TSX: begin x_next = sp; flags_next = mie_pkg::set_nz(flags, sp); end
      mie_pkg::TXA: begin acc_next = idx_x; flags_next = mie_pkg::set_nz(flags, idx_x); end
      mie_pkg::TYA: begin acc_next = idx_y; flags_next = mie_pkg::set_nz(flags, idx_y); end
      mie_pkg::TXS: sp_next = idx_x;
      default: ;  // NOP and unused codes
    endcase
    if (take) pc_next = head.target;
  end

  // Sequencing, architectural state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      acc       <= 8'h00;
      idx_x     <= 8'h00;
      idx_y     <= 8'h00;
      sp        <= mie_pkg::SP_RESET;
      flags     <= mie_pkg::FLAGS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (phase1) begin
        state <= ST_SECOND;
        if (head.mode == mie_pkg::JSR) sp <= sp - 8'd1;
      end else if (pop) begin
        state     <= ST_RUN;
        acc       <= acc_next;
        idx_x     <= x_next;
        idx_y     <= y_next;
        sp        <= sp_next;
        flags     <= flags_next;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.mem_write     <= wr_next;
      out_item.write_address <= wr_next ? head.address : 16'h0000;
      out_item.write_data    <= wd_next;
      out_item.new_pc        <= pc_next;
      out_item.acc_out       <= acc_next;
      out_item.x_out         <= x_next;
      out_item.y_out         <= y_next;
      out_item.sp_out        <= sp_next;
      out_item.flags_out     <= flags_next;
    end
  end

`ifndef SYNTHESIS
  a_second_has_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SECOND) |-> (head_valid && head.two_phase))
    else $error("second stack cycle without a two-phase instruction");
  a_phase1_moves: assert property (@(posedge clk) disable iff (rst)
    phase1 |=> (state == ST_SECOND))
    else $error("first stack cycle not followed by second");
  a_no_pull_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && head_valid) |-> !head.is_pull)
    else $error("stack written during a pull");
  a_no_pop_in_phase1: assert property (@(posedge clk) disable iff (rst)
    !(pop && phase1))
    else $error("instruction retired in its stack read cycle");
`endif

endmodule

### sv/mos6502_instruction_execute.sv
// 6502 execute unit, top level. Depends on mie_pkg, mie_front, mie_fifo, mie_back.
// Executes one decoded instruction per transaction and returns one result with the
// optional data write, new PC and all registers. Most instructions retire one per
// cycle unless the output stalls; PLA, PLP, RTS and JSR first take a stack access
// phase in the back end, as the stack RAM has a registered read and a single write
// port. A two-entry queue separates the accepting front end from the back end; a
// result register holds a stalled result. The stack RAM needs no clearing after reset.
module mos6502_instruction_execute #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mie_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mie_pkg::out_item_t out_item
);

  logic              q_push, q_full, q_pop, head_valid;
  mie_pkg::op_item_t q_item, head;

  mie_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  mie_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mie_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

### tb/tb.sv
// Testbench for the 6502 execute unit: random and directed instruction streams,
// checked against an in-bench behavioural predictor. Depends on mie_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps the CPU state shadow and the queue of expected results
  class exec_scoreboard;
    logic [7:0] acc, xr, yr, sp, st;
    logic [7:0] stack_mem [256];
    bit         written [256];
    mie_pkg::out_item_t pending [$];
    int         errors;

    function void clear();
      acc = 8'h00; xr = 8'h00; yr = 8'h00; sp = mie_pkg::SP_RESET;
      st = mie_pkg::FLAGS_RESET;
      pending.delete();
      errors = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void nz(logic [7:0] v);
      st[mie_pkg::FL_Z] = (v == 8'h00);
      st[mie_pkg::FL_N] = v[7];
    endfunction

    function void push(logic [7:0] v);
      stack_mem[sp] = v;
      written[sp] = 1;
      sp = sp - 8'd1;
    endfunction

    function logic [7:0] pull();
      sp = sp + 8'd1;
      return stack_mem[sp];
    endfunction

    function void add(logic [7:0] m);
      logic [8:0] s;
      s = {1'b0, acc} + {1'b0, m} + {8'h00, st[mie_pkg::FL_C]};
      st[mie_pkg::FL_C] = s[8];
      st[mie_pkg::FL_V] = (acc[7] ^ s[7]) & (m[7] ^ s[7]);
      acc = s[7:0];
      nz(acc);
    endfunction

    function void cmp(logic [7:0] r, logic [7:0] m);
      st[mie_pkg::FL_C] = (r >= m);
      nz(r - m);
    endfunction

    function logic [7:0] shift(mie_pkg::mnemonic_t op, logic [7:0] v);
      logic [7:0] r;
      logic       cin;
      cin = st[mie_pkg::FL_C];
      if (op == mie_pkg::ASL || op == mie_pkg::ROL) begin
        st[mie_pkg::FL_C] = v[7];
        r = {v[6:0], (op == mie_pkg::ROL) ? cin : 1'b0};
      end else begin
        st[mie_pkg::FL_C] = v[0];
        r = {(op == mie_pkg::ROR) ? cin : 1'b0, v[7:1]};
      end
      nz(r);
      return r;
    endfunction

    // True when the instruction would pull a never-written entry
    function bit pull_unsafe(logic [5:0] mode);
      if (mode == mie_pkg::PLA || mode == mie_pkg::PLP) return !written[sp + 8'd1];
      if (mode == mie_pkg::RTS) return !written[sp + 8'd1] || !written[sp + 8'd2];
      return 0;
    endfunction

    // Note an accepted instruction and queue its expected result
    function void note_input(mie_pkg::in_item_t it);
      mie_pkg::out_item_t r;
      mie_pkg::mnemonic_t op;
      logic [7:0]  m, lo, hi;
      logic [15:0] ret;
      bit          take;
      op = mie_pkg::mnemonic_t'(it.mode);
      m = it.operand;
      r = '0;
      r.new_pc = it.fetch_pc;
      take = 0;
      case (op)
        mie_pkg::ADC: add(m);
        mie_pkg::SBC: add(~m);
        mie_pkg::AND_: begin acc = acc & m; nz(acc); end
        mie_pkg::ORA: begin acc = acc | m; nz(acc); end
        mie_pkg::EOR: begin acc = acc ^ m; nz(acc); end
        mie_pkg::ASL, mie_pkg::LSR, mie_pkg::ROL, mie_pkg::ROR: begin
          if (it.accumulator_form) acc = shift(op, acc);
          else begin
            r.write_data = shift(op, m);
            r.mem_write = 1;
          end
        end
        mie_pkg::BCC: take = !st[mie_pkg::FL_C];
        mie_pkg::BCS: take = st[mie_pkg::FL_C];
        mie_pkg::BEQ: take = st[mie_pkg::FL_Z];
        mie_pkg::BNE: take = !st[mie_pkg::FL_Z];
        mie_pkg::BMI: take = st[mie_pkg::FL_N];
        mie_pkg::BPL: take = !st[mie_pkg::FL_N];
        mie_pkg::BVC: take = !st[mie_pkg::FL_V];
        mie_pkg::BVS: take = st[mie_pkg::FL_V];
        mie_pkg::BIT: begin
          st[mie_pkg::FL_Z] = ((acc & m) == 8'h00);
          st[mie_pkg::FL_V] = m[6];
          st[mie_pkg::FL_N] = m[7];
        end
        mie_pkg::CLC: st[mie_pkg::FL_C] = 0;
        mie_pkg::CLD: st[mie_pkg::FL_D] = 0;
        mie_pkg::CLI: st[mie_pkg::FL_I] = 0;
        mie_pkg::CLV: st[mie_pkg::FL_V] = 0;
        mie_pkg::SEC: st[mie_pkg::FL_C] = 1;
        mie_pkg::SED: st[mie_pkg::FL_D] = 1;
        mie_pkg::SEI: st[mie_pkg::FL_I] = 1;
        mie_pkg::CMP: cmp(acc, m);
        mie_pkg::CPX: cmp(xr, m);
        mie_pkg::CPY: cmp(yr, m);
        mie_pkg::DEC: begin
          r.write_data = m - 8'd1; r.mem_write = 1; nz(r.write_data);
        end
        mie_pkg::INC: begin
          r.write_data = m + 8'd1; r.mem_write = 1; nz(r.write_data);
        end
        mie_pkg::DEX: begin xr = xr - 8'd1; nz(xr); end
        mie_pkg::DEY: begin yr = yr - 8'd1; nz(yr); end
        mie_pkg::INX: begin xr = xr + 8'd1; nz(xr); end
        mie_pkg::INY: begin yr = yr + 8'd1; nz(yr); end
        mie_pkg::JMP: r.new_pc = it.address;
        mie_pkg::JSR: begin
          ret = it.fetch_pc - 16'd1;
          push(ret[15:8]);
          push(ret[7:0]);
          r.new_pc = it.address;
        end
        mie_pkg::LDA: begin acc = m; nz(m); end
        mie_pkg::LDX: begin xr = m; nz(m); end
        mie_pkg::LDY: begin yr = m; nz(m); end
        mie_pkg::PHA: push(acc);
        mie_pkg::PHP: push(st | 8'h30);
        mie_pkg::PLA: begin acc = pull(); nz(acc); end
        mie_pkg::PLP: begin
          st = pull(); st[mie_pkg::FL_B] = 0; st[mie_pkg::FL_U] = 1;
        end
        mie_pkg::RTS: begin
          lo = pull();
          hi = pull();
          r.new_pc = {hi, lo} + 16'd1;
        end
        mie_pkg::STA: begin r.write_data = acc; r.mem_write = 1; end
        mie_pkg::STX: begin r.write_data = xr; r.mem_write = 1; end
        mie_pkg::STY: begin r.write_data = yr; r.mem_write = 1; end
        mie_pkg::TAX: begin xr = acc; nz(xr); end
        mie_pkg::TAY: begin yr = acc; nz(yr); end
        mie_pkg::TSX: begin xr = sp; nz(xr); end
        mie_pkg::TXA: begin acc = xr; nz(acc); end
        mie_pkg::TXS: sp = xr;
        mie_pkg::TYA: begin acc = yr; nz(acc); end
        default: ;
      endcase
      if (take) r.new_pc = it.fetch_pc + {{8{m[7]}}, m};
      if (r.mem_write) r.write_address = it.address;
      r.acc_out = acc; r.x_out = xr; r.y_out = yr; r.sp_out = sp; r.flags_out = st;
      pending.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(mie_pkg::out_item_t got);
      mie_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.mem_write !== e.mem_write)
        report("mem_write", 16'(e.mem_write), 16'(got.mem_write));
      if (got.write_address !== e.write_address)
        report("write_address", e.write_address, got.write_address);
      if (got.write_data !== e.write_data)
        report("write_data", 16'(e.write_data), 16'(got.write_data));
      if (got.new_pc !== e.new_pc) report("new_pc", e.new_pc, got.new_pc);
      if (got.acc_out !== e.acc_out)
        report("acc_out", 16'(e.acc_out), 16'(got.acc_out));
      if (got.x_out !== e.x_out) report("x_out", 16'(e.x_out), 16'(got.x_out));
      if (got.y_out !== e.y_out) report("y_out", 16'(e.y_out), 16'(got.y_out));
      if (got.sp_out !== e.sp_out) report("sp_out", 16'(e.sp_out), 16'(got.sp_out));
      if (got.flags_out !== e.flags_out)
        report("flags_out", 16'(e.flags_out), 16'(got.flags_out));
    endfunction

    function void report(string f, logic [15:0] e, logic [15:0] a);
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, f, e, a);
      errors++;
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  mie_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1;
  mie_pkg::out_item_t out_item;

  exec_scoreboard sb = new();
  int  cycle = 0;
  int  idle_pct = 20;     // per-side idling, percent
  bit  hold_off = 0;      // long receiver stall request

  mos6502_instruction_execute i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1;
    else if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Offer one transaction and wait for its acceptance
  task automatic send(mie_pkg::in_item_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic op(mie_pkg::mnemonic_t m, logic [7:0] opd, logic af = 1'b0,
                    logic [15:0] a = 16'h1234, logic [15:0] pc = 16'h8000);
    mie_pkg::in_item_t it;
    it.mode = m; it.accumulator_form = af; it.operand = opd;
    it.address = a; it.fetch_pc = pc;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Random instruction; pulls only from entries already written
  function automatic mie_pkg::in_item_t rand_item();
    mie_pkg::in_item_t it;
    int                r;
    r = $urandom_range(99);
    it.accumulator_form = 1'($urandom_range(1));
    it.operand = (r < 10) ? (($urandom_range(1)) ? 8'hFF : 8'h00) : 8'($urandom);
    it.address = 16'($urandom);
    it.fetch_pc = 16'($urandom);
    it.mode = 6'($urandom_range(63));
    // bias towards stack activity: JSR, PHA, PHP and RTS
    if (r >= 80) begin
      it.mode = (r < 88) ? mie_pkg::JSR : (r < 93) ? mie_pkg::PHA :
                (r < 96) ? mie_pkg::PHP : mie_pkg::RTS;
    end
    // re-pick any pull that would read an empty stack slot
    while (sb.pull_unsafe(it.mode)) it.mode = 6'($urandom_range(63));
    return it;
  endfunction

  initial begin
    mie_pkg::in_item_t it;
    repeat (3) @(posedge clk);
    rst <= 0;
    sb.clear();

    // Directed: extremes, every mnemonic, special cases
    op(mie_pkg::LDA, 8'hFF); op(mie_pkg::ADC, 8'h01); op(mie_pkg::ADC, 8'h7F);
    op(mie_pkg::SBC, 8'h80);
    op(mie_pkg::ASL, 8'hFF, 1'b1); op(mie_pkg::ROR, 8'h01, 1'b0, 16'hFFFF);
    op(mie_pkg::LSR, 8'h00, 1'b0, 16'h0000);
    op(mie_pkg::ROL, 8'h80, 1'b1); op(mie_pkg::INC, 8'hFF); op(mie_pkg::DEC, 8'h00);
    op(mie_pkg::BIT, 8'hC0); op(mie_pkg::BMI, 8'h80, 1'b0, 16'h0000, 16'h0010);
    op(mie_pkg::BVS, 8'h7F, 1'b0, 16'h0000, 16'hFFF0);
    op(mie_pkg::PHP, 8'h00); op(mie_pkg::PLP, 8'h00);
    op(mie_pkg::JSR, 8'h00, 1'b0, 16'hABCD, 16'h0000); op(mie_pkg::RTS, 8'h00);
    op(mie_pkg::LDX, 8'h00); op(mie_pkg::TXS, 8'h00); op(mie_pkg::PHA, 8'h00);
    op(mie_pkg::PLA, 8'h00); op(mie_pkg::TSX, 8'h00);
    for (int m = 0; m < 64; m++) begin
      it = '0; it.mode = 6'(m); it.operand = 8'($urandom);
      it.fetch_pc = 16'($urandom);
      it.address = 16'($urandom);
      if (!sb.pull_unsafe(it.mode)) send(it);
    end

    // Random part, first with no idling at all
    idle_pct = 0;
    repeat (150) send(rand_item());
    idle_pct = 20;
    repeat (400) send(rand_item());

    // Sender pauses until every result is in
    drain();

    // Receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      repeat (20) send(rand_item());
    join
    repeat (600) send(rand_item());

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### files.f
sv/mie_pkg.sv
sv/mie_ram.sv
sv/mie_front.sv
sv/mie_fifo.sv
sv/mie_back.sv
sv/mos6502_instruction_execute.sv
tb/tb.sv
